// ----- rtl/mrrc_pkg.sv -----
package mrrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_MASK = 8'h80;
    localparam int unsigned MIN_LEN  = 5;

    // Byte positions inside the frame
    localparam int unsigned POS_SLAVE   = 0;
    localparam int unsigned POS_FUNC    = 1;
    localparam int unsigned POS_W1_HIGH = 2;
    localparam int unsigned POS_W1_LOW  = 3;
    localparam int unsigned POS_W2_HIGH = 4;
    localparam int unsigned POS_W2_LOW  = 5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_CRC   = 2'd2;
    localparam logic [1:0] ST_EXC   = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slave_addr;
        logic [7:0]  func_code;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [15:0] computed_crc;
    } t_result;

    // Bytewise CRC-16/MODBUS update, reflected form
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/modbus_rtu_response_checker_top.sv -----
// Channel   | Handshake                  | Payload
// rx (in)   | i_rx_valid / o_rx_stall    | i_rx_byte, i_frame_end
// res (out) | o_res_valid / i_res_stall  | o_status .. o_computed_crc
//
// One byte per cycle while o_rx_stall is low; once a frame's final byte is taken,
// its verdict goes into the result register, or the skid entry while output stalls.
// The CRC step per byte is one unrolled eight-bit update, computed combinationally.
// Reset is synchronous; reset and each final byte return the frame state to start.
// A skid entry behind the result register lets bytes flow while a verdict
// waits; o_rx_stall rises only when both entries hold a verdict.
module modbus_rtu_response_checker_top #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slave_addr,
    output logic [7:0]  o_func_code,
    output logic [15:0] o_first_word,
    output logic [15:0] o_second_word,
    output logic [15:0] o_computed_crc
);
    import mrrc_pkg::*;

    logic    rx_accept;
    logic    res_new;
    logic    buf_full;
    t_result res_comb, res_out;

    assign o_rx_stall = buf_full;
    assign rx_accept  = i_rx_valid && !buf_full;

    mrrc_frame #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (rx_accept),
        .i_rx_byte  (i_rx_byte),
        .i_frame_end(i_frame_end),
        .o_res_new  (res_new),
        .o_res      (res_comb)
    );

    mrrc_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_new  (res_new),
        .i_res  (res_comb),
        .i_stall(i_res_stall),
        .o_valid(o_res_valid),
        .o_res  (res_out),
        .o_full (buf_full)
    );

    assign o_status       = res_out.status;
    assign o_slave_addr   = res_out.slave_addr;
    assign o_func_code    = res_out.func_code;
    assign o_first_word   = res_out.first_word;
    assign o_second_word  = res_out.second_word;
    assign o_computed_crc = res_out.computed_crc;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid)
        else $error("skid entry holds a verdict while the result register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall && !i_res_stall |=> !o_rx_stall)
        else $error("skid entry not drained after result beat");

    a_exc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_status == ST_EXC || o_status == ST_OK)
            |-> (o_func_code[7] == (o_status == ST_EXC)))
        else $error("exception status disagrees with function bit 7");

endmodule

// ----- rtl/mrrc_frame.sv -----
module mrrc_frame #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_end,
    output logic               o_res_new,
    output mrrc_pkg::t_result  o_res
);
    import mrrc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [7:0]       r_tail0, r_tail1;
    logic [15:0]      r_crc;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_slave, r_func;
    logic [15:0]      r_word1, r_word2;

    logic [7:0]       n_slave, n_func;
    logic [15:0]      n_word1, n_word2;
    logic [15:0]      n_crc;
    logic [15:0]      got_crc;
    logic [1:0]       status;

    always_comb begin
        // oldest delayed byte enters the CRC once two bytes are queued
        n_crc = (r_cnt >= CNT_W'(2)) ? crc_byte(r_crc, r_tail0) : r_crc;

        n_slave = r_slave;
        n_func  = r_func;
        n_word1 = r_word1;
        n_word2 = r_word2;
        if (r_cnt == CNT_W'(POS_SLAVE))   n_slave = i_rx_byte;
        if (r_cnt == CNT_W'(POS_FUNC))    n_func  = i_rx_byte;
        if (r_cnt == CNT_W'(POS_W1_HIGH)) n_word1 = {i_rx_byte, r_word1[7:0]};
        if (r_cnt == CNT_W'(POS_W1_LOW))  n_word1 = {r_word1[15:8], i_rx_byte};
        if (r_cnt == CNT_W'(POS_W2_HIGH)) n_word2 = {i_rx_byte, r_word2[7:0]};
        if (r_cnt == CNT_W'(POS_W2_LOW))  n_word2 = {r_word2[15:8], i_rx_byte};

        got_crc = {i_rx_byte, r_tail1};
        if (r_cnt < CNT_W'(MIN_LEN - 1)) begin
            status = ST_SHORT;
        end else if (got_crc != n_crc) begin
            status = ST_CRC;
        end else if ((n_func & EXC_MASK) != 8'h00) begin
            status = ST_EXC;
        end else begin
            status = ST_OK;
        end

        o_res.status       = status;
        o_res.slave_addr   = n_slave;
        o_res.func_code    = n_func;
        o_res.first_word   = n_word1;
        o_res.second_word  = n_word2;
        o_res.computed_crc = n_crc;
    end

    assign o_res_new = i_accept & i_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_new) begin
            r_tail0 <= 8'h00;
            r_tail1 <= 8'h00;
            r_crc   <= CRC_INIT;
            r_cnt   <= '0;
            r_slave <= 8'h00;
            r_func  <= 8'h00;
            r_word1 <= 16'h0000;
            r_word2 <= 16'h0000;
        end else if (i_accept) begin
            r_tail0 <= r_tail1;
            r_tail1 <= i_rx_byte;
            r_crc   <= n_crc;
            r_slave <= n_slave;
            r_func  <= n_func;
            r_word1 <= n_word1;
            r_word2 <= n_word2;
            // saturate the byte count
            if (r_cnt < CNT_W'(MAX_FRAME_BYTES)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/mrrc_out_buf.sv -----
module mrrc_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_new,
    input  mrrc_pkg::t_result  i_res,
    input  logic               i_stall,
    output logic               o_valid,
    output mrrc_pkg::t_result  o_res,
    output logic               o_full
);
    import mrrc_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // drain the skid first, then take a fresh verdict
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_new;
            end else begin
                r_out_valid  <= i_new;
            end
        end else if (i_new) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_new) r_skid <= i_res;
            end else if (i_new) begin
                r_out <= i_res;
            end
        end else if (i_new) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule

// ----- tb/sv/modbus_rtu_response_checker_top_test.sv -----
module modbus_rtu_response_checker_top_test;
    import mrrc_pkg::*;

    localparam int FRAME_BYTES_CAP = 256;
    localparam int RANDOM_BYTES    = 1650;
    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AT_VERDICT = 20;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_IDLE        = 14;

    typedef enum int {FRAME_GOOD_CRC, FRAME_BAD_CRC, FRAME_RAW} t_frame_kind;

    class verdict_scoreboard;
        t_result     expected_verdicts[$];
        logic [7:0]  tail[2];
        logic [15:0] crc;
        logic [8:0]  count;
        logic [7:0]  slave;
        logic [7:0]  func;
        logic [15:0] word_one;
        logic [15:0] word_two;
        int unsigned mismatches;

        function new();
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            tail[0]  = 8'h00;
            tail[1]  = 8'h00;
            crc      = CRC_INIT;
            count    = 9'd0;
            slave    = 8'h00;
            func     = 8'h00;
            word_one = 16'h0000;
            word_two = 16'h0000;
        endfunction

        // Shift one byte through the reflected CRC, bit 0 first
        static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = c;
            for (int i = 0; i < 8; i++) begin
                fb = r[0] ^ b[i];
                r  = r >> 1;
                if (fb) begin
                    r = r ^ CRC_POLY;
                end
            end
            return r;
        endfunction

        function void note_byte(logic [7:0] b, logic is_final);
            t_result     v;
            logic [15:0] trailer;
            // The byte leaving the two-byte delay enters the CRC
            if (count >= 2) begin
                crc = crc16_step(crc, tail[0]);
            end
            case (count)
                POS_SLAVE:   slave          = b;
                POS_FUNC:    func           = b;
                POS_W1_HIGH: word_one[15:8] = b;
                POS_W1_LOW:  word_one[7:0]  = b;
                POS_W2_HIGH: word_two[15:8] = b;
                POS_W2_LOW:  word_two[7:0]  = b;
                default: ;
            endcase
            if (!is_final) begin
                tail[0] = tail[1];
                tail[1] = b;
                if (count < FRAME_BYTES_CAP) begin
                    count = count + 9'd1;
                end
                return;
            end
            trailer = {b, tail[1]};
            if (int'(count) + 1 < MIN_LEN) begin
                v.status = ST_SHORT;
            end else if (trailer != crc) begin
                v.status = ST_CRC;
            end else if ((func & EXC_MASK) != 8'h00) begin
                v.status = ST_EXC;
            end else begin
                v.status = ST_OK;
            end
            v.slave_addr   = slave;
            v.func_code    = func;
            v.first_word   = word_one;
            v.second_word  = word_two;
            v.computed_crc = crc;
            expected_verdicts = {expected_verdicts, v};
            clear_frame();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_verdict(t_result got);
            t_result want;
            if (expected_verdicts.size() == 0) begin
                $error("verdict beat with no frame pending");
                mismatches++;
                return;
            end
            want = expected_verdicts.pop_front();
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("slave_addr", 16'(want.slave_addr), 16'(got.slave_addr));
            compare_field("func_code", 16'(want.func_code), 16'(got.func_code));
            compare_field("first_word", want.first_word, got.first_word);
            compare_field("second_word", want.second_word, got.second_word);
            compare_field("computed_crc", want.computed_crc, got.computed_crc);
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_rx_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        i_res_stall = 1'b0;
    logic        o_rx_stall;
    logic        o_res_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_slave_addr;
    logic [7:0]  o_func_code;
    logic [15:0] o_first_word;
    logic [15:0] o_second_word;
    logic [15:0] o_computed_crc;

    verdict_scoreboard board;
    logic [7:0]        frame_buf[$];
    int                bytes_sent;

    modbus_rtu_response_checker_top #(
        .MAX_FRAME_BYTES(FRAME_BYTES_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .i_frame_end   (i_frame_end),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_status      (o_status),
        .o_slave_addr  (o_slave_addr),
        .o_func_code   (o_func_code),
        .o_first_word  (o_first_word),
        .o_second_word (o_second_word),
        .o_computed_crc(o_computed_crc)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Fill frame_buf: slave and function up front, random body, CRC trailer unless raw
    function void build_frame(int len, t_frame_kind kind, logic [7:0] slave, logic [7:0] func);
        logic [15:0] crc;
        frame_buf.delete();
        for (int k = 0; k < len; k++) begin
            frame_buf = {frame_buf, 8'($urandom)};
        end
        frame_buf[0] = slave;
        if (len > 1) begin
            frame_buf[1] = func;
        end
        if (kind != FRAME_RAW && len >= 2) begin
            crc = CRC_INIT;
            for (int k = 0; k < len - 2; k++) begin
                crc = verdict_scoreboard::crc16_step(crc, frame_buf[k]);
            end
            if (kind == FRAME_BAD_CRC) begin
                crc = crc ^ 16'($urandom_range(1, 65535));
            end
            frame_buf[len - 2] = crc[7:0];
            frame_buf[len - 1] = crc[15:8];
        end
    endfunction

    task automatic send_frame();
        int gap;
        int pace;
        pace = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
        foreach (frame_buf[k]) begin
            gap = $urandom_range(0, pace);
            if (gap > 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_rx_valid  <= 1'b1;
            i_rx_byte   <= frame_buf[k];
            i_frame_end <= (k == frame_buf.size() - 1);
            do @(posedge i_clk); while (o_rx_stall);
            board.note_byte(frame_buf[k], k == frame_buf.size() - 1);
            bytes_sent++;
        end
    endtask

    initial begin
        int len;
        int pick;
        board = new();
        bytes_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short frames of one, two and four bytes; length wins over CRC
        build_frame(1, FRAME_GOOD_CRC, 8'hFF, 8'h00);
        send_frame();
        build_frame(2, FRAME_GOOD_CRC, 8'h00, 8'h00);
        send_frame();
        build_frame(4, FRAME_GOOD_CRC, 8'h01, 8'h03);
        send_frame();
        // Minimal good frame: second word carries only its high byte
        build_frame(5, FRAME_GOOD_CRC, 8'hFF, 8'h7F);
        send_frame();
        build_frame(6, FRAME_GOOD_CRC, 8'h00, 8'h83);
        send_frame();
        // Exception function with a broken trailer reports the CRC first
        build_frame(5, FRAME_BAD_CRC, 8'h11, 8'hFF);
        send_frame();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(5, 12);
            // Overlong frames push the byte count into saturation
            if (bytes_sent == 0 || $urandom_range(0, 59) == 0) begin
                len = $urandom_range(FRAME_BYTES_CAP + 1, FRAME_BYTES_CAP + 44);
            end
            if (pick < 70) begin
                build_frame(len, FRAME_GOOD_CRC, 8'($urandom), 8'($urandom));
            end else if (pick < 85) begin
                build_frame(len, FRAME_BAD_CRC, 8'($urandom), 8'($urandom));
            end else if (pick < 93) begin
                build_frame($urandom_range(1, 4), pick[0] ? FRAME_GOOD_CRC : FRAME_BAD_CRC,
                            8'($urandom), 8'($urandom));
            end else begin
                build_frame($urandom_range(1, 20), FRAME_RAW, 8'($urandom), 8'($urandom));
            end
            send_frame();
        end

        i_rx_valid <= 1'b0;
        while (board.expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        t_result got;
        int      hold;
        int      pace;
        int      verdicts_seen;
        verdicts_seen = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            pace = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
            // Hold off once for long enough that both verdict entries fill
            hold = (verdicts_seen == HOLD_AT_VERDICT) ? HOLD_CYCLES : $urandom_range(0, pace);
            if (hold > 0) begin
                i_res_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_res_stall <= 1'b0;
            do @(posedge i_clk); while (!o_res_valid);
            got.status       = o_status;
            got.slave_addr   = o_slave_addr;
            got.func_code    = o_func_code;
            got.first_word   = o_first_word;
            got.second_word  = o_second_word;
            got.computed_crc = o_computed_crc;
            board.check_verdict(got);
            verdicts_seen++;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_rx_valid && !o_rx_stall) || (o_res_valid && !i_res_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $error("no beat moved for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- modbus_rtu_response_checker_top.f -----
rtl/mrrc_pkg.sv
rtl/mrrc_frame.sv
rtl/mrrc_out_buf.sv
rtl/modbus_rtu_response_checker_top.sv
tb/sv/modbus_rtu_response_checker_top_test.sv
